// ----- rtl/lrg_pkg.sv -----
// ----------------------------------------------------------------------------
// lrg_pkg: shared types and constants of the linear ramp generator
// Fixed field widths, request kinds, register indexes and the status bundle
// of the iterative divider.
// ----------------------------------------------------------------------------
package lrg_pkg;

	// Fixed widths of the request and result fields.
	localparam int KIND_W   = 2;
	localparam int VALUE_W  = 32;
	localparam int LENGTH_W = 24;
	localparam int VSIZE_W  = 13;

	// Request kinds.
	localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_START = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STOP  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_SET   = 2'd3;

	// Configuration register indexes.
	localparam logic REG_RAMP_MODE   = 1'b0;
	localparam logic REG_VECTOR_SIZE = 1'b1;

	// Status of the iterative divider as seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- rtl/linear_ramp_generator_top.sv -----
// ----------------------------------------------------------------------------
// linear_ramp_generator_top: linear ramp generator
// Q16.16 ramp with a wide fractional accumulator, step computed by an
// iterative divider, one result per request.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  kind, target, length
//  res      out        res_valid/res_stall  value, ramping
//  cfg      in         cfg_we               cfg_index, cfg_data
//
//  A ramp-moving tick passes accept with multiply, add and clamp, and result
//  load; other ticks, stop, set and zero-length start go from accept to result
//  load. A start with nonzero length passes accept, prepare, divide and result
//  load; the divider gives one quotient bit per cycle. A result waits in the
//  output register while res_stall is high, and the next request is taken
//  meanwhile. Reset clears the ramp state and loads the register defaults.
// ----------------------------------------------------------------------------
module linear_ramp_generator_top #(
	parameter int LENGTH_BITS = 24,
	parameter int FRAC_BITS   = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [lrg_pkg::KIND_W-1:0]          kind,
	input  logic signed [lrg_pkg::VALUE_W-1:0]  target,
	input  logic [lrg_pkg::LENGTH_W-1:0]        length,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic signed [lrg_pkg::VALUE_W-1:0]  value,
	output logic                                ramping,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [lrg_pkg::VSIZE_W-1:0]         cfg_data
);

	localparam int ACC_W   = 16 + FRAC_BITS;
	localparam int DIFF_W  = ACC_W + 1;
	localparam int PROD_W  = ACC_W + lrg_pkg::VSIZE_W + 1;
	localparam int NXT_W   = PROD_W + 1;
	localparam int SHIFT   = FRAC_BITS - 16;
	localparam int LEN_USE = (LENGTH_BITS < lrg_pkg::LENGTH_W) ? LENGTH_BITS : lrg_pkg::LENGTH_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_ADD  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]                 state_q;
	logic                       mode_q;
	logic [lrg_pkg::VSIZE_W-1:0] vsize_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [ACC_W-1:0]    step_q;
	logic signed [lrg_pkg::VALUE_W-1:0] goal_q;
	logic                       falling_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [DIFF_W-1:0]   diff_q;
	logic [LEN_USE-1:0]         length_q;
	logic                       res_valid_q;
	logic signed [lrg_pkg::VALUE_W-1:0] res_value_q;
	logic                       res_ramping_q;

	logic                       accept;
	logic signed [ACC_W-1:0]    target_acc;
	logic signed [ACC_W-1:0]    goal_acc;
	logic [lrg_pkg::VSIZE_W-1:0] mult;
	logic signed [NXT_W-1:0]    nxt;
	logic signed [NXT_W-1:0]    goal_ext;
	logic                       reached;
	logic [DIFF_W-1:0]          diff_mag;
	logic [DIFF_W-1:0]          quo;
	logic signed [ACC_W-1:0]    new_step;
	logic                       res_free;
	lrg_pkg::div_stat_t         div_stat;

	assign accept     = req_valid && !req_stall;
	assign req_stall  = state_q != ST_IDLE;
	assign target_acc = ACC_W'(target) <<< SHIFT;
	assign goal_acc   = ACC_W'(goal_q) <<< SHIFT;
	assign mult       = mode_q ? vsize_q : lrg_pkg::VSIZE_W'(1);
	assign nxt        = NXT_W'(acc_q) + NXT_W'(prod_q);
	assign goal_ext   = NXT_W'(goal_acc);
	assign reached    = falling_q ? (nxt <= goal_ext) : (nxt >= goal_ext);
	assign diff_mag   = diff_q[DIFF_W-1] ? (~diff_q + DIFF_W'(1)) : diff_q;
	assign res_free   = !res_valid_q || !res_stall;

	// Saturate the quotient to the accumulator range, then apply the sign.
	always_comb begin
		if (quo[ACC_W] || quo[ACC_W-1]) begin
			new_step = diff_q[DIFF_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else if (diff_q[DIFF_W-1]) begin
			new_step = -signed'(quo[ACC_W-1:0]);
		end else begin
			new_step = signed'(quo[ACC_W-1:0]);
		end
	end

	lrg_div #(
		.DIVIDEND_W(DIFF_W),
		.DIVISOR_W (LEN_USE)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == ST_PREP),
		.dividend(diff_mag),
		.divisor (length_q),
		.quotient(quo),
		.stat    (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b1;
			vsize_q <= lrg_pkg::VSIZE_W'(64);
		end else if (cfg_we) begin
			unique case (cfg_index)
				lrg_pkg::REG_RAMP_MODE:   mode_q  <= cfg_data[0];
				lrg_pkg::REG_VECTOR_SIZE: vsize_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			step_q      <= '0;
			goal_q      <= '0;
			falling_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			// In the result-load state the valid flag is written below instead.
			if (res_valid_q && !res_stall && state_q != ST_OUT) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (kind)
							lrg_pkg::KIND_TICK: begin
								state_q <= (step_q != '0) ? ST_ADD : ST_OUT;
							end
							lrg_pkg::KIND_START: begin
								goal_q <= target;
								if (length[LEN_USE-1:0] == '0) begin
									step_q    <= '0;
									acc_q     <= target_acc;
									falling_q <= 1'b0;
									state_q   <= ST_OUT;
								end else begin
									state_q <= ST_PREP;
								end
							end
							lrg_pkg::KIND_STOP: begin
								step_q  <= '0;
								state_q <= ST_OUT;
							end
							lrg_pkg::KIND_SET: begin
								acc_q   <= target_acc;
								state_q <= ST_OUT;
							end
							default: ;
						endcase
					end
				end
				ST_PREP: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						step_q    <= new_step;
						falling_q <= new_step[ACC_W-1];
						state_q   <= ST_OUT;
					end
				end
				ST_ADD: begin
					// The clamp lands exactly on the goal and ends the ramp.
					if (reached) begin
						step_q <= '0;
						acc_q  <= goal_acc;
					end else begin
						acc_q <= nxt[ACC_W-1:0];
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (res_free) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; the product is formed in the accept cycle of a tick.
	always_ff @(posedge clk) begin
		if (accept) begin
			prod_q   <= PROD_W'(step_q * signed'({1'b0, mult}));
			diff_q   <= DIFF_W'(target_acc) - DIFF_W'(acc_q);
			length_q <= length[LEN_USE-1:0];
		end
		if (state_q == ST_OUT && res_free) begin
			res_value_q   <= acc_q[ACC_W-1:SHIFT];
			res_ramping_q <= step_q != '0;
		end
	end

	assign res_valid = res_valid_q;
	assign value     = res_value_q;
	assign ramping   = res_ramping_q;

`ifndef SYNTHESIS
	// A result appears only out of the result-load state.
	a_res_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == ST_OUT)
		else $error("result raised outside the result-load state");

	// The divider reports completion only while the sequencer waits for it.
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	// The add-and-clamp step always follows an accepted tick.
	a_add_after_tick: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ADD |-> $past(state_q) == ST_IDLE && $past(step_q) != '0)
		else $error("add step entered without a moving tick");
`endif

endmodule

// ----- rtl/lrg_div.sv -----
// ----------------------------------------------------------------------------
// lrg_div: iterative unsigned restoring divider
// One quotient bit per cycle through a single subtract and compare.
// ----------------------------------------------------------------------------
module lrg_div #(
	parameter int DIVIDEND_W = 49,
	parameter int DIVISOR_W  = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic [DIVIDEND_W-1:0] quotient,
	output lrg_pkg::div_stat_t    stat
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [CNT_W-1:0]      cnt_q;
	logic                  done_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  div_q;

	logic [DIVISOR_W:0] trial;
	logic [DIVISOR_W:0] trial_sub;
	logic               fits;

	// The dividend shifts out of quo_q from the top while quotient bits enter below.
	assign trial     = {rem_q, quo_q[DIVIDEND_W-1]};
	assign trial_sub = trial - {1'b0, div_q};
	assign fits      = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(DIVIDEND_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = cnt_q != '0;
	assign stat.done = done_q;

endmodule
